>>> rtl/sgpw_pkg.sv
// Shared types, codes and the 5x8 font table for the scaled glyph page writer.
// No dependencies; used by sgpw_ctrl, sgpw_datapath and the top level.
`timescale 1ns / 1ps

package sgpw_pkg;

   localparam logic [7:0] DISPLAY_WIDTH = 8'd96;
   localparam logic [8:0] PAGE_LIMIT    = 9'd5;
   localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
   localparam logic [7:0] COL_OFFSET    = 8'd32;
   localparam logic [6:0] FIRST_CHAR    = 7'd32;
   localparam logic [6:0] LAST_CHAR     = 7'd126;
   localparam logic [2:0] LAST_COL      = 3'd5;
   localparam logic [2:0] SCALE_MIN     = 3'd1;
   localparam logic [2:0] SCALE_MAX     = 3'd4;
   localparam int         GLYPHS        = 95;

   localparam logic [1:0] OP_SET_CURSOR = 2'd0;
   localparam logic [1:0] OP_PUT_CHAR   = 2'd1;
   localparam logic [1:0] OP_PUT_STRING = 2'd2;
   localparam logic [1:0] OP_NONE       = 2'd3;

   localparam logic CSR_SCALE_X = 1'b0;
   localparam logic CSR_SCALE_Y = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GLYPH,
      ST_WRAP
   } state_type;

   typedef struct packed {
      logic set_cursor;
      logic load_item;
      logic emit_glyph;
      logic emit_wrap;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic glyph_last;
      logic wrap;
   } status_type;

   // One glyph per entry, column 0 in the top byte.
   localparam logic [39:0] GLYPH_ROM [GLYPHS] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
      40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
      40'h0000703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
      40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
      40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
      40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
      40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
      40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
      40'h0003070800, 40'h2054543840, 40'h7F28444438, 40'h3844444428,
      40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h0C52524A3C,
      40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
      40'h7C18242418, 40'h182424187C, 40'h7C08040408, 40'h4854545424,
      40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h4C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h0000770000, 40'h0041360800, 40'h0201020402
   };

   function automatic logic [2:0] clamp_scale(input logic [2:0] s);
      logic [2:0] r;
      r = s;
      if (s < SCALE_MIN) r = SCALE_MIN;
      else if (s > SCALE_MAX) r = SCALE_MAX;
      return r;
   endfunction

   // Stretch each bit of a column byte to sy bits, bit 0 lowest.
   function automatic logic [31:0] expand_column(input logic [7:0] b, input logic [2:0] sy);
      logic [31:0] w;
      w = '0;
      case (sy)
         3'd2: for (int k = 0; k < 8; k++) w[k*2 +: 2] = {2{b[k]}};
         3'd3: for (int k = 0; k < 8; k++) w[k*3 +: 3] = {3{b[k]}};
         3'd4: for (int k = 0; k < 8; k++) w[k*4 +: 4] = {4{b[k]}};
         default: w[7:0] = b;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/sgpw_ctrl.sv
// Sequencer for the scaled glyph page writer: accepts items and steps the
// datapath through glyph and wrap results. Depends on sgpw_pkg.
`timescale 1ns / 1ps

module sgpw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_op,
   output logic                  req_stall,
   input  sgpw_pkg::status_type  status,
   output sgpw_pkg::cmd_type     cmd
);

   sgpw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgpw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgpw_pkg::ST_IDLE: begin
            if (req_valid && status.out_free &&
                (req_op == sgpw_pkg::OP_PUT_CHAR || req_op == sgpw_pkg::OP_PUT_STRING)) begin
               state_in = sgpw_pkg::ST_GLYPH;
            end
         end
         sgpw_pkg::ST_GLYPH: begin
            if (status.out_free && status.glyph_last) begin
               state_in = status.wrap ? sgpw_pkg::ST_WRAP : sgpw_pkg::ST_IDLE;
            end
         end
         sgpw_pkg::ST_WRAP: begin
            if (status.out_free) begin
               state_in = sgpw_pkg::ST_IDLE;
            end
         end
         default: state_in = sgpw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sgpw_pkg::ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               unique case (req_op)
                  sgpw_pkg::OP_SET_CURSOR: cmd.set_cursor = 1'b1;
                  sgpw_pkg::OP_PUT_CHAR,
                  sgpw_pkg::OP_PUT_STRING: cmd.load_item = 1'b1;
                  default: ;
               endcase
            end
         end
         sgpw_pkg::ST_GLYPH: cmd.emit_glyph = status.out_free;
         sgpw_pkg::ST_WRAP:  cmd.emit_wrap  = status.out_free;
         default: ;
      endcase
   end

endmodule

>>> rtl/sgpw_datapath.sv
// Datapath of the scaled glyph page writer: cursor, scale registers, glyph
// latch, column/slice counters and the result register. Depends on sgpw_pkg.
`timescale 1ns / 1ps

module sgpw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_op,
   input  logic [6:0]            req_ch,
   input  logic [7:0]            req_x_pos,
   input  logic [7:0]            req_y_pos,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [2:0]            csr_wdata,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_page_cmd,
   output logic [4:0]            rsp_col_high_cmd,
   output logic [3:0]            rsp_col_low_cmd,
   output logic [7:0]            rsp_data_byte,
   output logic [2:0]            rsp_data_count,
   output logic                  rsp_last,
   input  sgpw_pkg::cmd_type     cmd,
   output sgpw_pkg::status_type  status
);

   logic [2:0]  scale_x_ff, scale_y_ff;
   logic [7:0]  cursor_col_ff, cursor_page_ff;
   logic [39:0] glyph_ff;
   logic        string_ff;
   logic [2:0]  col_idx_ff;
   logic [1:0]  slice_ff;
   logic [7:0]  col_base_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_page_ff, rsp_col_ff, rsp_data_ff;
   logic [2:0]  rsp_count_ff;
   logic        rsp_last_ff;

   logic        printable;
   logic [6:0]  rom_index;
   logic [7:0]  step;
   logic [7:0]  next_col;
   logic        wrap;
   logic [7:0]  page_sum;
   logic        page_zero;
   logic        slice_last;
   logic        glyph_last;
   logic [7:0]  col_byte;
   logic [31:0] word;
   logic [7:0]  slice_byte;
   logic [7:0]  col_addr;
   logic        out_free;

   assign printable = (req_ch >= sgpw_pkg::FIRST_CHAR) && (req_ch <= sgpw_pkg::LAST_CHAR);
   assign rom_index = printable ? (req_ch - sgpw_pkg::FIRST_CHAR) : 7'd0;

   // advance is 6 * scale_x
   assign step     = {3'b000, scale_x_ff, 2'b00} + {4'b0000, scale_x_ff, 1'b0};
   assign next_col = cursor_col_ff + step;
   assign wrap     = next_col >= sgpw_pkg::DISPLAY_WIDTH;
   assign page_sum = cursor_page_ff + {5'b00000, scale_y_ff};
   assign page_zero = ({1'b0, page_sum} + {6'b000000, scale_y_ff}) >= sgpw_pkg::PAGE_LIMIT;

   assign slice_last = ({1'b0, slice_ff} == (scale_y_ff - 3'd1));
   assign glyph_last = slice_last && (col_idx_ff == sgpw_pkg::LAST_COL);

   always_comb begin
      case (col_idx_ff)
         3'd0:    col_byte = glyph_ff[39:32];
         3'd1:    col_byte = glyph_ff[31:24];
         3'd2:    col_byte = glyph_ff[23:16];
         3'd3:    col_byte = glyph_ff[15:8];
         3'd4:    col_byte = glyph_ff[7:0];
         default: col_byte = 8'h00;
      endcase
   end

   // shift the glyph down one pixel, then stretch vertically
   assign word       = sgpw_pkg::expand_column({col_byte[6:0], 1'b0}, scale_y_ff);
   assign slice_byte = word[slice_ff*8 +: 8];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.out_free   = out_free;
   assign status.glyph_last = glyph_last;
   assign status.wrap       = wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= sgpw_pkg::SCALE_MIN;
         scale_y_ff <= sgpw_pkg::SCALE_MIN;
      end else if (csr_wr_en) begin
         if (csr_index == sgpw_pkg::CSR_SCALE_X) scale_x_ff <= sgpw_pkg::clamp_scale(csr_wdata);
         else                                    scale_y_ff <= sgpw_pkg::clamp_scale(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff  <= '0;
         cursor_page_ff <= '0;
      end else if (cmd.set_cursor) begin
         cursor_col_ff  <= req_x_pos;
         cursor_page_ff <= req_y_pos;
      end else if (cmd.emit_glyph && glyph_last) begin
         if (wrap) begin
            cursor_col_ff  <= {7'd0, string_ff};
            cursor_page_ff <= page_zero ? 8'd0 : page_sum;
         end else begin
            cursor_col_ff  <= next_col + {7'd0, string_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         glyph_ff    <= printable ? sgpw_pkg::GLYPH_ROM[rom_index] : 40'd0;
         string_ff   <= (req_op == sgpw_pkg::OP_PUT_STRING);
         col_idx_ff  <= '0;
         slice_ff    <= '0;
         col_base_ff <= cursor_col_ff;
      end else if (cmd.emit_glyph) begin
         if (slice_last) begin
            slice_ff    <= '0;
            col_idx_ff  <= col_idx_ff + 3'd1;
            col_base_ff <= col_base_ff + {5'd0, scale_x_ff};
         end else begin
            slice_ff    <= slice_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.set_cursor || cmd.emit_glyph || cmd.emit_wrap) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_cursor) begin
         rsp_page_ff  <= req_y_pos;
         rsp_col_ff   <= req_x_pos;
         rsp_data_ff  <= 8'h00;
         rsp_count_ff <= 3'd0;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit_glyph) begin
         rsp_page_ff  <= cursor_page_ff + {6'd0, slice_ff};
         rsp_col_ff   <= col_base_ff;
         rsp_data_ff  <= slice_byte;
         rsp_count_ff <= scale_x_ff;
         rsp_last_ff  <= glyph_last && !wrap;
      end else if (cmd.emit_wrap) begin
         rsp_page_ff  <= cursor_page_ff;
         rsp_col_ff   <= 8'd0;
         rsp_data_ff  <= 8'h00;
         rsp_count_ff <= 3'd0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign col_addr         = rsp_col_ff + sgpw_pkg::COL_OFFSET;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_cmd     = sgpw_pkg::PAGE_CMD_BASE | rsp_page_ff;
   assign rsp_col_high_cmd = {1'b1, col_addr[7:4]};
   assign rsp_col_low_cmd  = col_addr[3:0];
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_data_count   = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> rtl/scaled_glyph_page_writer_unit.sv
// Top level of the scaled glyph page writer: sequencer plus datapath.
// Depends on sgpw_pkg, sgpw_ctrl and sgpw_datapath.
//
// Usage:
//   req_* carries one operation per transfer (set cursor, put character,
//   put string character). rsp_* carries page-mode write results, each with
//   page, column-high and column-low commands and a data byte to be written
//   rsp_data_count times; rsp_last marks the final result of an operation.
//   csr_* writes scale_x (index 0) and scale_y (index 1), clamped to 1..4;
//   write only while the block is idle.
// Timing:
//   Every result leaves through one output register, in the cycle after it
//   is formed. A set cursor gives 1 result. A character gives 6*scale_y
//   results, plus one more when the cursor wraps; the result sequencer
//   forms one result per cycle while the output is not stalled, and a new
//   item is taken only once the previous one is finished.
//   Op 3 is taken and gives nothing.
// Reset clears the cursor to column 0, page 0 and both scales to 1.
// While rsp_stall is high the held result stays put and the sequencer waits.
`timescale 1ns / 1ps

module scaled_glyph_page_writer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [6:0] req_ch,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_page_cmd,
   output logic [4:0] rsp_col_high_cmd,
   output logic [3:0] rsp_col_low_cmd,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_data_count,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [2:0] csr_wdata
);

   sgpw_pkg::cmd_type    cmd;
   sgpw_pkg::status_type status;

   sgpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sgpw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_ch           (req_ch),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_page_cmd     (rsp_page_cmd),
      .rsp_col_high_cmd (rsp_col_high_cmd),
      .rsp_col_low_cmd  (rsp_col_low_cmd),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_count   (rsp_data_count),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> verif/sgpw_write_checker.sv
// Watches the request, result and register ports of the glyph page writer,
// predicts every page write and compares it field by field with the output.
// Depends on sgpw_pkg for the op and register codes.
`timescale 1ns / 1ps

module sgpw_write_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [6:0] req_ch,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_page_cmd,
   input  logic [4:0] rsp_col_high_cmd,
   input  logic [3:0] rsp_col_low_cmd,
   input  logic [7:0] rsp_data_byte,
   input  logic [2:0] rsp_data_count,
   input  logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [2:0] csr_wdata,
   output int         mismatch_count,
   output int         writes_outstanding
);

   localparam int         SCREEN_COLS = 96;
   localparam int         PAGE_ROWS   = 5;
   localparam logic [7:0] PAGE_OPCODE = 8'hB0;
   localparam logic [7:0] COL_SKEW    = 8'd32;

   typedef struct packed {
      logic [7:0] page_cmd;
      logic [4:0] col_high_cmd;
      logic [3:0] col_low_cmd;
      logic [7:0] data_byte;
      logic [2:0] data_count;
      logic       last;
   } page_write_type;

   // Printable glyphs from space up, column 0 in the top byte.
   localparam logic [39:0] FONT_5X8 [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
      40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
      40'h0000703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
      40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
      40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
      40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
      40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
      40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
      40'h0003070800, 40'h2054543840, 40'h7F28444438, 40'h3844444428,
      40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h0C52524A3C,
      40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
      40'h7C18242418, 40'h182424187C, 40'h7C08040408, 40'h4854545424,
      40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h4C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h0000770000, 40'h0041360800, 40'h0201020402
   };

   page_write_type pending_page_writes[$];
   page_write_type oldest;
   logic [7:0]     cursor_col;
   logic [7:0]     cursor_page;
   logic [2:0]     scale_x_reg;
   logic [2:0]     scale_y_reg;

   function automatic int effective_scale(input logic [2:0] raw);
      if (raw == 3'd0) return 1;
      if (raw > 3'd4) return 4;
      return int'(raw);
   endfunction

   function automatic void push_write(input logic [7:0] page, input logic [7:0] col,
                                      input logic [7:0] data, input logic [2:0] count,
                                      input logic is_last);
      page_write_type w;
      logic [7:0]     addr;
      addr           = col + COL_SKEW;
      w.page_cmd     = PAGE_OPCODE | page;
      w.col_high_cmd = {1'b1, addr[7:4]};
      w.col_low_cmd  = addr[3:0];
      w.data_byte    = data;
      w.data_count   = count;
      w.last         = is_last;
      pending_page_writes.push_back(w);
   endfunction

   function automatic void render_request(input logic [1:0] op, input logic [6:0] code,
                                          input logic [7:0] x, input logic [7:0] y);
      int          sx;
      int          sy;
      logic [39:0] glyph;
      logic [7:0]  column;
      logic [31:0] stretched;
      logic [7:0]  next_col;
      logic        wraps;
      if (op == sgpw_pkg::OP_SET_CURSOR) begin
         cursor_col  = x;
         cursor_page = y;
         push_write(y, x, 8'h00, 3'd0, 1'b1);
         return;
      end
      if (op == sgpw_pkg::OP_NONE) return;
      sx       = effective_scale(scale_x_reg);
      sy       = effective_scale(scale_y_reg);
      glyph    = (code >= 7'd32 && code <= 7'd126) ? FONT_5X8[code - 7'd32] : '0;
      next_col = 8'(int'(cursor_col) + 6 * sx);
      wraps    = (int'(next_col) >= SCREEN_COLS);
      for (int i = 0; i < 6; i++) begin
         // sixth column is blank; glyph drops one pixel
         column = (i < 5) ? {glyph[38 - 8 * i -: 7], 1'b0} : 8'h00;
         stretched = '0;
         for (int k = 0; k < 8; k++)
            for (int r = 0; r < sy; r++)
               stretched[k * sy + r] = column[k];
         for (int j = 0; j < sy; j++)
            push_write(8'(int'(cursor_page) + j), 8'(int'(cursor_col) + i * sx),
                       stretched[8 * j +: 8], 3'(sx),
                       !wraps && i == 5 && j == sy - 1);
      end
      if (wraps) begin
         cursor_col  = 8'h00;
         cursor_page = 8'(int'(cursor_page) + sy);
         if (int'(cursor_page) >= PAGE_ROWS - sy) cursor_page = 8'h00;
         push_write(cursor_page, 8'h00, 8'h00, 3'd0, 1'b1);
      end else begin
         cursor_col = next_col;
      end
      if (op == sgpw_pkg::OP_PUT_STRING) cursor_col = cursor_col + 8'd1;
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_page_writes.delete();
         cursor_col     = 8'h00;
         cursor_page    = 8'h00;
         scale_x_reg    = 3'd1;
         scale_y_reg    = 3'd1;
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == sgpw_pkg::CSR_SCALE_X) scale_x_reg = csr_wdata;
            else scale_y_reg = csr_wdata;
         end
         if (req_valid && !req_stall) render_request(req_op, req_ch, req_x_pos, req_y_pos);
         if (rsp_valid && !rsp_stall) begin
            if (pending_page_writes.size() == 0) begin
               $error("unexpected page write transfer: page_cmd 0x%0h data_byte 0x%0h",
                      rsp_page_cmd, rsp_data_byte);
               mismatch_count++;
            end else begin
               oldest = pending_page_writes.pop_front();
               compare_field("page_cmd", int'(oldest.page_cmd), int'(rsp_page_cmd));
               compare_field("col_high_cmd", int'(oldest.col_high_cmd),
                             int'(rsp_col_high_cmd));
               compare_field("col_low_cmd", int'(oldest.col_low_cmd),
                             int'(rsp_col_low_cmd));
               compare_field("data_byte", int'(oldest.data_byte), int'(rsp_data_byte));
               compare_field("data_count", int'(oldest.data_count),
                             int'(rsp_data_count));
               compare_field("last", int'(oldest.last), int'(rsp_last));
            end
         end
      end
      writes_outstanding <= pending_page_writes.size();
   end

endmodule

>>> verif/tb_top.sv
// Top of the glyph page writer regression: clock, reset, request and register
// stimulus, random output stalls and the verdict. Depends on sgpw_pkg,
// scaled_glyph_page_writer_unit and sgpw_write_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int ITEMS_PER_PHASE = 33;
   localparam int SETTLE_CYCLES   = 40;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_op           = sgpw_pkg::OP_SET_CURSOR;
   logic [6:0] req_ch           = 7'd0;
   logic [7:0] req_x_pos        = 8'd0;
   logic [7:0] req_y_pos        = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_page_cmd;
   logic [4:0] rsp_col_high_cmd;
   logic [3:0] rsp_col_low_cmd;
   logic [7:0] rsp_data_byte;
   logic [2:0] rsp_data_count;
   logic       rsp_last;
   logic       csr_wr_en        = 1'b0;
   logic       csr_index        = sgpw_pkg::CSR_SCALE_X;
   logic [2:0] csr_wdata        = 3'd0;

   int         mismatch_count;
   int         writes_outstanding;
   int         cycle_count      = 0;
   logic       quiet            = 1'b0;
   int         stall_left       = 0;
   int         calm_left        = 0;

   scaled_glyph_page_writer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_ch           (req_ch),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_page_cmd     (rsp_page_cmd),
      .rsp_col_high_cmd (rsp_col_high_cmd),
      .rsp_col_low_cmd  (rsp_col_low_cmd),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_count   (rsp_data_count),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   sgpw_write_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_ch             (req_ch),
      .req_x_pos          (req_x_pos),
      .req_y_pos          (req_y_pos),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_page_cmd       (rsp_page_cmd),
      .rsp_col_high_cmd   (rsp_col_high_cmd),
      .rsp_col_low_cmd    (rsp_col_low_cmd),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_data_count     (rsp_data_count),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .writes_outstanding (writes_outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Output backpressure: stall bursts, calm stretches, none once quiet.
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && calm_left == 0) begin
            case ($urandom_range(0, 7))
               0, 1: stall_left = $urandom_range(1, 16);
               2: calm_left = $urandom_range(20, 80);
               default: ;
            endcase
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (calm_left > 0) calm_left--;
         end
      end
   end

   function automatic logic [6:0] random_code();
      if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(32, 126));
   endfunction

   // Hold the transfer until the block takes it; scramble the payload in gaps.
   task automatic send_op(input logic [1:0] op, input logic [6:0] code,
                          input logic [7:0] x, input logic [7:0] y);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_op    <= 2'($urandom_range(0, 3));
         req_ch    <= 7'($urandom_range(0, 127));
         req_x_pos <= 8'($urandom_range(0, 255));
         req_y_pos <= 8'($urandom_range(0, 255));
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_ch    <= code;
      req_x_pos <= x;
      req_y_pos <= y;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (writes_outstanding != 0) @(posedge clock);
      // op 3 leaves nothing to wait for, so give the block time to settle
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scales(input logic [2:0] sx, input logic [2:0] sy);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sgpw_pkg::CSR_SCALE_X;
      csr_wdata <= sx;
      @(negedge clock);
      csr_index <= sgpw_pkg::CSR_SCALE_Y;
      csr_wdata <= sy;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [2:0] sx, input logic [2:0] sy, input logic calm);
      int pick;
      int sent;
      drain();
      write_scales(sx, sy);
      quiet = calm;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         if ($urandom_range(0, 19) == 0)
            send_op(sgpw_pkg::OP_NONE, 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         pick = $urandom_range(0, 99);
         if (pick < 4)
            send_op(sgpw_pkg::OP_SET_CURSOR, random_code(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
         else if (pick < 10)
            send_op(sgpw_pkg::OP_SET_CURSOR, random_code(), 8'($urandom_range(0, 95)),
                    8'($urandom_range(0, 4)));
         else if (pick < 60)
            send_op(sgpw_pkg::OP_PUT_CHAR, random_code(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
         else
            send_op(sgpw_pkg::OP_PUT_STRING, random_code(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
         sent++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset scales: cursor loads, odd codes, column and page wraps
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd0, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd65, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd0, 8'd255, 8'd255);
      send_op(sgpw_pkg::OP_PUT_STRING, 7'd127, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd31, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd32, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_STRING, 7'd126, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_NONE, 7'd127, 8'd255, 8'd255);
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd127, 8'd90, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd35, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd0, 8'd90, 8'd3);
      send_op(sgpw_pkg::OP_PUT_STRING, 7'd126, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd0, 8'd255, 8'd255);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd87, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_STRING, 7'd103, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd0, 8'd95, 8'd4);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd90, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd0, 8'hAA, 8'h55);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'h55, 8'h55, 8'hAA);
      send_op(sgpw_pkg::OP_SET_CURSOR, 7'd0, 8'd89, 8'd2);
      send_op(sgpw_pkg::OP_PUT_STRING, 7'd64, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd36, 8'd0, 8'd0);
      send_op(sgpw_pkg::OP_PUT_CHAR, 7'd109, 8'd0, 8'd0);

      run_phase(3'd4, 3'd4, 1'b0);
      run_phase(3'd0, 3'd0, 1'b0);
      run_phase(3'd7, 3'd2, 1'b0);
      run_phase(3'd2, 3'd7, 1'b0);
      run_phase(3'd3, 3'd1, 1'b0);
      run_phase(3'd1, 3'd3, 1'b0);
      run_phase(3'd5, 3'd6, 1'b1);
      drain();

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
